// ===== sv/ase_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Array search engine package
// Shared constants, operation codes and the controller state type.
// ----------------------------------------------------------------------------
package ase_pkg;

    localparam int TABLE_DEPTH_DEF = 128;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 7;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;
    localparam int BND_W   = IDX_W + 2;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_LINEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_BINARY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LINEAR,
        ST_BIN_PROBE,
        ST_BIN_CHECK,
        ST_RESULT
    } state_t;

endpackage : ase_pkg
`default_nettype wire

// ===== sv/array_search_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Array search engine core
// Table of signed 32-bit elements with write, linear search and binary search.
// ----------------------------------------------------------------------------
// The block takes one item at a time and gives one result per item. A write
// item stores its value and goes straight to the result. A linear search reads
// one table entry per cycle from the single read port of the element memory,
// up to min(used_count, depth) entries, and stops at the first match. A binary
// search probes by a memory read, then a compare, until the key is found or
// the bounds cross. The result waits in an output register, and the next item
// is taken while it waits. Entries read by a search must have been written
// first.
module array_search_engine_core #(
    parameter int TABLE_DEPTH = ase_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [ase_pkg::COUNT_W-1:0] used_count,

    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ase_pkg::OP_W-1:0]    op,
    input  wire logic [ase_pkg::IDX_W-1:0]   index,
    input  wire logic signed [ase_pkg::DATA_W-1:0] value,
    input  wire logic [ase_pkg::IDX_W-1:0]   lower_bound,
    input  wire logic [ase_pkg::IDX_W-1:0]   upper_bound,

    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             found,
    output logic [ase_pkg::IDX_W-1:0]        position
);

    import ase_pkg::*;

    localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAX_IDX = TABLE_DEPTH - 1;

    logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [15:0]              rd_wide;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [15:0]              wr_wide;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]       used_count_reg;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [COUNT_W-1:0]       scan_reg, scan_next;
    logic [COUNT_W-1:0]       limit_reg, limit_next;
    logic                     pend_reg, pend_next;
    logic [COUNT_W-1:0]       pend_idx_reg, pend_idx_next;
    logic signed [BND_W-1:0]  lo_reg, lo_next;
    logic signed [BND_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]         mid_reg, mid_next;
    logic                     res_found_reg, res_found_next;
    logic [IDX_W-1:0]         res_pos_reg, res_pos_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg;
    logic [IDX_W-1:0]         position_reg;

    logic                     in_fire;
    logic                     out_load;
    logic                     lin_hit;
    logic                     bin_cross;
    logic [BND_W-1:0]         mid_sum;
    logic signed [BND_W-1:0]  hi_cut;
    logic [COUNT_W-1:0]       limit_cut;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    assign lin_hit   = pend_reg && (rd_data_reg == key_reg);
    assign bin_cross = (lo_reg > hi_reg);
    assign mid_sum   = {1'b0, lo_reg[BND_W-2:0]} + {1'b0, hi_reg[BND_W-2:0]};

    assign hi_cut = ((MAX_IDX < 127) && (32'(upper_bound) > 32'(MAX_IDX)))
                    ? BND_W'(MAX_IDX) : {2'b00, upper_bound};
    assign limit_cut = (32'(used_count_reg) > 32'(TABLE_DEPTH))
                       ? COUNT_W'(TABLE_DEPTH) : used_count_reg;

    assign wr_en   = in_fire && (op == OP_WRITE) && (32'(index) < 32'(TABLE_DEPTH));
    assign wr_wide = {9'b0, index};
    assign wr_addr = wr_wide[AW-1:0];

    always_comb
    begin
        rd_en   = 1'b0;
        rd_wide = {8'b0, scan_reg};
        if ((state_reg == ST_LINEAR) && !lin_hit && (scan_reg < limit_reg))
        begin
            rd_en = 1'b1;
        end
        else if ((state_reg == ST_BIN_PROBE) && !bin_cross)
        begin
            rd_en   = 1'b1;
            rd_wide = {8'b0, mid_sum[BND_W-1:1]};
        end
    end
    assign rd_addr = rd_wide[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op)
                        OP_LINEAR: state_next = ST_LINEAR;
                        OP_BINARY: state_next = ST_BIN_PROBE;
                        default:   state_next = ST_RESULT;
                    endcase
                end
            end
            ST_LINEAR:
            begin
                if (lin_hit || !(scan_reg < limit_reg))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_BIN_PROBE:
            begin
                state_next = bin_cross ? ST_RESULT : ST_BIN_CHECK;
            end
            ST_BIN_CHECK:
            begin
                state_next = (rd_data_reg == key_reg) ? ST_RESULT : ST_BIN_PROBE;
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        key_next       = key_reg;
        scan_next      = scan_reg;
        limit_next     = limit_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    key_next       = value;
                    scan_next      = '0;
                    limit_next     = limit_cut;
                    pend_next      = 1'b0;
                    lo_next        = {2'b00, lower_bound};
                    hi_next        = hi_cut;
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                end
            end
            ST_LINEAR:
            begin
                if (lin_hit)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = pend_idx_reg[IDX_W-1:0];
                end
                else if (scan_reg < limit_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg;
                    scan_next     = scan_reg + COUNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_BIN_PROBE:
            begin
                mid_next = mid_sum[IDX_W:1];
            end
            ST_BIN_CHECK:
            begin
                if (rd_data_reg == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = mid_reg;
                end
                else if (key_reg < rd_data_reg)
                begin
                    hi_next = {2'b00, mid_reg} - BND_W'(1);
                end
                else
                begin
                    lo_next = {2'b00, mid_reg} + BND_W'(1);
                end
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            if (cfg_valid && cfg_ready)
            begin
                used_count_reg <= used_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        scan_reg      <= scan_next;
        limit_reg     <= limit_next;
        pend_idx_reg  <= pend_idx_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        if (out_load)
        begin
            found_reg    <= res_found_reg;
            position_reg <= res_pos_reg;
        end
    end

    // An accepted item keeps the input closed until its result is produced.
    a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input ready stayed high after an item was accepted");

    // A result moved to the output register is visible on the next cycle.
    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("result load did not raise out_valid");

    // The linear scan never runs past its limit.
    a_scan_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINEAR) |-> (scan_reg <= limit_reg))
        else $error("linear scan index passed its limit");

    // Every probe of a binary search lies inside the current bounds.
    a_probe_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BIN_CHECK) |->
            (($signed({2'b00, mid_reg}) >= lo_reg) && ($signed({2'b00, mid_reg}) <= hi_reg)))
        else $error("binary probe outside the search bounds");

endmodule : array_search_engine_core
`default_nettype wire
